// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("never failed");
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("implies failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("next failed");
`else
`define ASSERT_NEVER(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== sv/nlj_pkg.sv =====
// shared types, codes and compare function of the join probe unit
package nlj_pkg;
  localparam int BUILD_DEPTH    = 64;
  localparam int MAX_CONDITIONS = 4;
  localparam int ROW_W          = $clog2(BUILD_DEPTH);
  localparam int CNT_W          = $clog2(BUILD_DEPTH + 1);

  typedef logic signed [31:0] key_t;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_PROBE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_INNER = 2'd0,
    MODE_SEMI  = 2'd1,
    MODE_ANTI  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_JOIN_MODE  = 2'd0,
    REG_COND_COUNT = 2'd1,
    REG_COMPARE_OPS = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_EQ = 3'd0,
    OP_NE = 3'd1,
    OP_LT = 3'd2,
    OP_GT = 3'd3,
    OP_LE = 3'd4,
    OP_GE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  // token travelling down the cell chain
  typedef struct packed {
    logic             active;
    logic             row_ok;
    logic             fin;
    logic             match;
    logic [ROW_W-1:0] row;
  } token_t;

  // per-cell condition setup
  typedef struct packed {
    logic       en;
    logic [2:0] op;
    key_t       key;
  } cell_cfg_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] addr;
  } cell_wr_t;

  function automatic logic op_holds(logic [2:0] op, key_t p, key_t r);
    logic h;
    case (op)
      OP_EQ:   h = (p == r);
      OP_NE:   h = (p != r);
      OP_LT:   h = (p < r);
      OP_GT:   h = (p > r);
      OP_LE:   h = (p <= r);
      OP_GE:   h = (p >= r);
      default: h = 1'b0;
    endcase
    return h;
  endfunction
endpackage

// ===== sv/nlj_ram.sv =====
// generic single write, single registered read memory
module nlj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/nlj_cell.sv =====
// one condition cell: holds one key column, tests it and passes the token on
module nlj_cell (
  input  logic              clk,
  input  logic              rst,
  input  nlj_pkg::cell_wr_t wr,
  input  nlj_pkg::key_t     wdata,
  input  nlj_pkg::cell_cfg_t cfg,
  input  nlj_pkg::token_t   tok_in,
  output nlj_pkg::token_t   tok_out
);
  import nlj_pkg::*;

  token_t s1;
  key_t   rd_key;
  logic   hold;

  nlj_ram #(.WIDTH(32), .DEPTH(BUILD_DEPTH)) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wdata),
    .raddr(tok_in.row),
    .rdata(rd_key)
  );

  assign hold = !cfg.en || op_holds(cfg.op, cfg.key, rd_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.active      <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      s1.active      <= tok_in.active;
      tok_out.active <= s1.active;
    end
    s1.row_ok      <= tok_in.row_ok;
    s1.fin         <= tok_in.fin;
    s1.match       <= tok_in.match;
    s1.row         <= tok_in.row;
    tok_out.row_ok <= s1.row_ok;
    tok_out.fin    <= s1.fin;
    tok_out.match  <= s1.match && hold;
    tok_out.row    <= s1.row;
  end
endmodule

// ===== sv/nested_loop_join_probe_unit.sv =====
// top level: build table in a chain of condition cells, probe sequencer, result stage
// a probe issues build_count + 1 tokens, one per cycle, into a chain of four cells of
// two stages each; busy stays high from the probe until its closing token leaves the
// chain, so no item is taken meanwhile; clear, load and ignored items leave the unit
// idle; reset empties the table, clears the overflow flag and loads register
// defaults; key memories are not cleared
// results come as one-cycle strobes and cannot be stalled
`include "assert_macros.svh"
module nested_loop_join_probe_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic [15:0]         probe_tag,
  input  logic signed [31:0]  key0,
  input  logic signed [31:0]  key1,
  input  logic signed [31:0]  key2,
  input  logic signed [31:0]  key3,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  output logic                result_valid,
  output logic [15:0]         matched_probe_tag,
  output logic [5:0]          build_index,
  output logic                last_of_run,
  output logic                table_overflow
);
  import nlj_pkg::*;

  // configuration registers
  logic [1:0]  join_mode;
  logic [2:0]  condition_count;
  logic [11:0] compare_ops;

  // table state
  logic [CNT_W-1:0] build_count;
  logic             overflow_seen;

  // sequencer
  state_t           state, state_next;
  logic [CNT_W-1:0] scan_row;
  logic [15:0]      tag;
  key_t             probe_key [MAX_CONDITIONS];
  key_t             in_key    [MAX_CONDITIONS];

  token_t    tok  [MAX_CONDITIONS+1];
  token_t    tok_head;
  cell_cfg_t ccfg [MAX_CONDITIONS];
  cell_wr_t  wr;

  // result stage
  logic             pend_valid;
  logic [ROW_W-1:0] pend_row;
  logic             any_match;

  logic accept, do_probe, tail_hit, tail_fin;

  assign in_key[0] = key0;
  assign in_key[1] = key1;
  assign in_key[2] = key2;
  assign in_key[3] = key3;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  // a probe in an unused join mode changes nothing
  assign do_probe  = accept && (kind == KIND_PROBE) &&
                     (join_mode == MODE_INNER || join_mode == MODE_SEMI ||
                      join_mode == MODE_ANTI);

  // configuration transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      join_mode       <= MODE_INNER;
      condition_count <= 3'd1;
      compare_ops     <= 12'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_JOIN_MODE:   join_mode       <= cfg_data[1:0];
        REG_COND_COUNT:  condition_count <= cfg_data[2:0];
        REG_COMPARE_OPS: compare_ops     <= cfg_data;
        default: ;
      endcase
    end
  end

  // table fill: load writes every key column at the fill count
  assign wr.we   = accept && (kind == KIND_LOAD) && (build_count < CNT_W'(BUILD_DEPTH));
  assign wr.addr = build_count[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      build_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (accept && kind == KIND_CLEAR) begin
      build_count <= '0;
    end else if (accept && kind == KIND_LOAD) begin
      if (wr.we) begin
        build_count <= build_count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // probe capture
  always_ff @(posedge clk) begin
    if (do_probe) begin
      tag <= probe_tag;
      for (int c = 0; c < MAX_CONDITIONS; c++) begin
        probe_key[c] <= in_key[c];
      end
    end
  end

  // scan sequencer: one token per row plus a closing token
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (do_probe) begin
      scan_row <= '0;
    end else if (state == ST_SCAN) begin
      scan_row <= scan_row + 1'b1;
    end
  end

  always_comb begin
    state_next      = state;
    tok_head.active = 1'b0;
    tok_head.row_ok = scan_row < build_count;
    tok_head.fin    = scan_row == build_count;
    tok_head.match  = 1'b1;
    tok_head.row    = scan_row[ROW_W-1:0];
    case (state)
      ST_IDLE: begin
        if (do_probe) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tok_head.active = 1'b1;
        if (tok_head.fin) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tail_fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign tok[0] = tok_head;

  // cell chain, one cell per key condition
  for (genvar c = 0; c < MAX_CONDITIONS; c++) begin : g_cell
    // counts above the cell number enable it, so large counts saturate
    assign ccfg[c].en  = condition_count > 3'(c);
    assign ccfg[c].op  = compare_ops[3*c +: 3];
    assign ccfg[c].key = probe_key[c];

    nlj_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr),
      .wdata  (in_key[c]),
      .cfg    (ccfg[c]),
      .tok_in (tok[c]),
      .tok_out(tok[c+1])
    );
  end

  // result stage: inner results are held one behind so the last can be marked
  assign tail_hit = tok[MAX_CONDITIONS].active && tok[MAX_CONDITIONS].row_ok &&
                    tok[MAX_CONDITIONS].match;
  assign tail_fin = tok[MAX_CONDITIONS].active && tok[MAX_CONDITIONS].fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      any_match    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (do_probe) begin
        pend_valid <= 1'b0;
        any_match  <= 1'b0;
      end
      if (tail_hit) begin
        any_match  <= 1'b1;
        pend_valid <= 1'b1;
        pend_row   <= tok[MAX_CONDITIONS].row;
        if (join_mode == MODE_INNER && pend_valid) begin
          result_valid <= 1'b1;
          build_index  <= pend_row;
          last_of_run  <= 1'b0;
        end
      end
      if (tail_fin) begin
        build_index <= '0;
        last_of_run <= 1'b1;
        case (join_mode)
          MODE_INNER: begin
            result_valid <= pend_valid;
            build_index  <= pend_row;
          end
          MODE_SEMI: result_valid <= any_match;
          MODE_ANTI: result_valid <= !any_match;
          default:   result_valid <= 1'b0;
        endcase
      end
    end
    matched_probe_tag <= tag;
    table_overflow    <= overflow_seen;
  end

  // checks
  `ASSERT_IMPLIES(a_result_in_probe, clk, rst, result_valid, $past(state) != ST_IDLE)
  `ASSERT_NEVER(a_count_bound, clk, rst, build_count > CNT_W'(BUILD_DEPTH))
  `ASSERT_NEXT(a_probe_busy, clk, rst, do_probe, busy && state == ST_SCAN)
endmodule

// ===== tb/tb_nested_loop_join_probe_unit.sv =====
// testbench of the join probe unit: directed and random items checked against a local predictor
module tb_nested_loop_join_probe_unit;
  import nlj_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [15:0] probe_tag;
  logic signed [31:0] key0, key1, key2, key3;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        result_valid;
  logic [15:0] matched_probe_tag;
  logic [5:0]  build_index;
  logic        last_of_run;
  logic        table_overflow;

  nested_loop_join_probe_unit dut (.*);

  // one expected result of a probe
  typedef struct {
    logic [15:0] tag;
    logic [5:0]  row;
    logic        last;
    logic        ovf;
  } match_t;

  match_t match_q[$];
  int     errors = 0;
  int     items_sent = 0;
  bit     no_gaps = 0;

  // predictor copy of the build table and registers
  key_t        tbl_keys[BUILD_DEPTH][MAX_CONDITIONS];
  int          tbl_rows;
  logic        tbl_ovf;
  logic [1:0]  cur_mode;
  logic [2:0]  cur_conds;
  logic [11:0] cur_ops;

  // key pool: a few values repeat so that equality tests hit often
  key_t key_pool[8];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // generous cap well above the slowest correct run
  initial begin
    #(20 * 1_000_000);
    $display("tb_nested_loop_join_probe_unit: FAIL");
    $finish;
  end

  function automatic logic cond_ok(logic [2:0] op, key_t p, key_t r);
    case (op)
      OP_EQ:   return p == r;
      OP_NE:   return p != r;
      OP_LT:   return p < r;
      OP_GT:   return p > r;
      OP_LE:   return p <= r;
      OP_GE:   return p >= r;
      default: return 1'b0; // codes six and seven never hold
    endcase
  endfunction

  // update the table state and queue the results of one accepted item
  task automatic predict_item(logic [1:0] k, logic [15:0] tag, key_t pk[4]);
    int     nc;
    bit     ok;
    bit     any;
    int     last_pos;
    match_t m;
    last_pos = -1;
    any = 0;
    if (k == KIND_CLEAR) begin
      tbl_rows = 0;
    end else if (k == KIND_LOAD) begin
      if (tbl_rows >= BUILD_DEPTH) tbl_ovf = 1'b1; // full table drops the row
      else begin
        for (int c = 0; c < MAX_CONDITIONS; c++) tbl_keys[tbl_rows][c] = pk[c];
        tbl_rows++;
      end
    end else if (k == KIND_PROBE && cur_mode <= MODE_ANTI) begin
      nc = (cur_conds > MAX_CONDITIONS) ? MAX_CONDITIONS : cur_conds;
      for (int r = 0; r < tbl_rows; r++) begin
        ok = 1;
        for (int c = 0; c < nc; c++)
          if (!cond_ok(cur_ops[3*c +: 3], pk[c], tbl_keys[r][c])) ok = 0;
        if (ok) begin
          any = 1;
          if (cur_mode == MODE_INNER) begin
            m.tag = tag; m.row = r[5:0]; m.last = 1'b0; m.ovf = tbl_ovf;
            match_q = {match_q, m};
            last_pos = match_q.size() - 1;
          end
        end
      end
      if (cur_mode == MODE_INNER) begin
        if (last_pos >= 0) match_q[last_pos].last = 1'b1;
      end else if ((cur_mode == MODE_SEMI && any) || (cur_mode == MODE_ANTI && !any)) begin
        m.tag = tag; m.row = '0; m.last = 1'b1; m.ovf = tbl_ovf;
        match_q = {match_q, m};
      end
    end
  endtask

  // result checker: values sampled before the edge's updates land
  always @(posedge clk) begin
    match_t m;
    if (!rst && result_valid) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result tag %h row %0d", $time, matched_probe_tag,
                 build_index);
        errors++;
      end else begin
        m = match_q.pop_front();
        if (matched_probe_tag !== m.tag) begin
          $display("%0t: tag exp %h got %h", $time, m.tag, matched_probe_tag);
          errors++;
        end
        if (build_index !== m.row) begin
          $display("%0t: build_index exp %0d got %0d", $time, m.row, build_index);
          errors++;
        end
        if (last_of_run !== m.last) begin
          $display("%0t: last_of_run exp %b got %b", $time, m.last, last_of_run);
          errors++;
        end
        if (table_overflow !== m.ovf) begin
          $display("%0t: table_overflow exp %b got %b", $time, m.ovf, table_overflow);
          errors++;
        end
      end
    end
  end

  // drive one item and hold it until the transfer; start stays high on return,
  // so the caller either sends again or calls gap in the same step
  task automatic send_item(logic [1:0] k, logic [15:0] tag, key_t pk[4]);
    start     <= 1'b1;
    kind      <= k;
    probe_tag <= tag;
    key0 <= pk[0]; key1 <= pk[1]; key2 <= pk[2]; key3 <= pk[3];
    do @(posedge clk); while (busy);
    predict_item(k, tag, pk);
    items_sent++;
  endtask

  task automatic gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random sender gaps, none in the final stretch
  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) gap($urandom_range(1, 3));
  endtask

  // drain every expected result, then cover a probe that ends with no result
  task automatic settle();
    gap(1);
    while (match_q.size() != 0) @(posedge clk);
    repeat (BUILD_DEPTH + 16) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_JOIN_MODE:   cur_mode  = val[1:0];
      REG_COND_COUNT:  cur_conds = val[2:0];
      REG_COMPARE_OPS: cur_ops   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic [2:0] n, logic [11:0] o);
    settle();
    write_reg(REG_JOIN_MODE, {10'd0, m});
    write_reg(REG_COND_COUNT, {9'd0, n});
    write_reg(REG_COMPARE_OPS, o);
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, 7)];
  endfunction

  task automatic random_keys(output key_t pk[4]);
    for (int c = 0; c < 4; c++) pk[c] = pick_key();
  endtask

  // extremes of the fields, every kind, odd register values
  task automatic test_directed();
    key_t pk[4];
    key_t zk[4];
    zk = '{0, 0, 0, 0};
    // reset defaults: inner, one condition, equality; empty table gives nothing
    send_item(KIND_PROBE, 16'h0000, zk);
    pk = '{32'sh8000_0000, 32'sh7fff_ffff, -1, 0};
    send_item(KIND_LOAD, 16'hffff, pk);
    send_item(KIND_LOAD, 16'h1234, zk);
    send_item(KIND_PROBE, 16'hffff, pk);
    send_item(KIND_PROBE, 16'h5a5a, zk);
    send_item(2'd3, 16'ha5a5, pk);              // unused kind is ignored
    send_item(KIND_PROBE, 16'h0001, '{32'sh7fff_ffff, 0, 0, 0});
    gap(1);
    // all four conditions, lt gt le ge
    configure(MODE_INNER, 3'd4, {OP_GE, OP_LE, OP_GT, OP_LT});
    send_item(KIND_PROBE, 16'h00aa, '{32'sh8000_0000, 0, 32'sh8000_0000, 0});
    gap(1);
    // count above four saturates, ne and never-match codes
    configure(MODE_SEMI, 3'd7, {3'd6, 3'd7, OP_NE, OP_NE});
    send_item(KIND_PROBE, 16'h00bb, zk);
    gap(1);
    configure(MODE_ANTI, 3'd0, 12'hfff);        // no conditions: every row matches
    send_item(KIND_PROBE, 16'h00cc, zk);
    send_item(KIND_CLEAR, 16'h0000, zk);
    send_item(KIND_PROBE, 16'h00dd, zk);        // anti on empty table
    gap(1);
    configure(2'd3, 3'd1, 12'h000);             // unused mode: probe gives nothing
    send_item(KIND_LOAD, 16'h0000, zk);
    send_item(KIND_PROBE, 16'h00ee, zk);
    gap(1);
    configure(MODE_SEMI, 3'd1, 12'h000);
    send_item(KIND_PROBE, 16'h00ef, zk);
    gap(1);
  endtask

  // fill the table, overflow it, then probe with every row matching
  task automatic test_overflow();
    key_t pk[4];
    configure(MODE_INNER, 3'd0, 12'h000);
    random_keys(pk);
    send_item(KIND_CLEAR, 16'h0, pk);
    for (int i = 0; i < BUILD_DEPTH + 2; i++) begin
      random_keys(pk);
      send_item(KIND_LOAD, $urandom, pk);
      maybe_gap();
    end
    for (int i = 0; i < 3; i++) begin
      random_keys(pk);
      send_item(KIND_PROBE, $urandom, pk);
      maybe_gap();
    end
    // sticky flag survives a clear
    send_item(KIND_CLEAR, 16'h0, pk);
    send_item(KIND_LOAD, 16'h0, pk);
    send_item(KIND_PROBE, 16'h7777, pk);
    gap(1);
  endtask

  // phases of a random setting: clear, a small table, then probes
  task automatic test_random_phases(int target);
    key_t pk[4];
    int   rows;
    int   roll;
    while (items_sent < target) begin
      roll = $urandom_range(0, 9);
      configure((roll == 0) ? 2'd3 : 2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)),
                (roll == 1) ? 12'h000 : (roll == 2) ? 12'hfff : 12'($urandom));
      for (int i = 0; i < 8; i++) key_pool[i] = (i < 3) ? key_t'($urandom) :
          key_t'($urandom_range(0, 1) ? 32'sh8000_0000 + i : 32'sh7fff_fff0 + i);
      random_keys(pk);
      send_item(KIND_CLEAR, $urandom, pk);
      rows = $urandom_range(0, 10);
      for (int i = 0; i < rows; i++) begin
        random_keys(pk);
        send_item(($urandom_range(0, 15) == 0) ? 2'd3 : KIND_LOAD, $urandom, pk);
        maybe_gap();
      end
      for (int i = 0; i < 12; i++) begin
        random_keys(pk);
        roll = $urandom_range(0, 19);
        send_item((roll == 0) ? 2'd3 : (roll == 1) ? KIND_LOAD : KIND_PROBE, $urandom, pk);
        // sender holds off until the block has delivered everything
        if (roll == 2) begin
          gap(1);
          while (match_q.size() != 0) @(posedge clk);
        end else maybe_gap();
      end
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; kind = '0; probe_tag = '0;
    key0 = '0; key1 = '0; key2 = '0; key3 = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    tbl_rows = 0; tbl_ovf = 1'b0;
    cur_mode = MODE_INNER; cur_conds = 3'd1; cur_ops = '0;
    for (int i = 0; i < 8; i++) key_pool[i] = key_t'(i - 2);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phases(260);
    test_overflow();
    test_random_phases(380);
    no_gaps = 1;              // closing stretch runs back to back
    test_random_phases(430);

    settle();
    if (errors == 0) begin
      $display("tb_nested_loop_join_probe_unit: PASS");
    end else begin
      $display("tb_nested_loop_join_probe_unit: FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/nlj_pkg.sv
sv/nlj_ram.sv
sv/nlj_cell.sv
sv/nested_loop_join_probe_unit.sv
tb/tb_nested_loop_join_probe_unit.sv
